// ===== design/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope gain block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package adsr_pkg;

	localparam int LVL_W = 25;
	localparam int SMP_W = 24;
	localparam int RF_W  = 24;
	localparam int CMD_W = 2;
	localparam int IDX_W = 2;
	localparam int PH_W  = 3;
	localparam int MUL_W = 26;

	localparam logic [LVL_W-1:0] LEVEL_ONE = 25'd16777216;

	localparam logic [LVL_W-1:0] RST_ATTACK  = 25'd380;
	localparam logic [LVL_W-1:0] RST_DECAY   = 25'd380;
	localparam logic [LVL_W-1:0] RST_SUSTAIN = 25'd8388608;
	localparam logic [RF_W-1:0]  RST_RELEASE = 24'd16775075;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_RESET    = 2'd3
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} reg_idx_t;

	typedef enum logic [PH_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef struct packed {
		logic take;
		logic step;
		logic rel_load;
		logic mul_en;
		logic mul_rel;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_sample;
		logic rel_mul;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== design/adsr_in_if.sv =====
// Input channel: valid/ready handshake carrying a command and an audio sample.
// Depends on adsr_pkg for field widths.
interface adsr_in_if;
	import adsr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic signed [SMP_W-1:0] sample_in;

	modport source (output valid, output cmd, output sample_in, input ready);
	modport sink (input valid, input cmd, input sample_in, output ready);
endinterface

// ===== design/adsr_out_if.sv =====
// Output channel: valid/ready handshake carrying the scaled sample and envelope state.
// Depends on adsr_pkg for field widths.
interface adsr_out_if;
	import adsr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample_out;
	logic [LVL_W-1:0]        envelope_level;
	logic [PH_W-1:0]         phase_out;

	modport source (output valid, output sample_out, output envelope_level,
		output phase_out, input ready);
	modport sink (input valid, input sample_out, input envelope_level,
		input phase_out, output ready);
endinterface

// ===== design/adsr_envelope_gain_top.sv =====
// ADSR envelope gain. After acceptance a sample transaction passes the step, gain and
// load states, plus a release state in release with a nonzero envelope (extra pass
// through the shared multiplier). Input is taken only in idle; a command gives no result.
// A full result register stalls the sequencer in its load step only.
// Reset: phase idle, envelope zero, registers at their defaults, result register empty.
module adsr_envelope_gain_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [adsr_pkg::IDX_W-1:0] cfg_idx,
	input  logic [adsr_pkg::LVL_W-1:0] cfg_data,
	adsr_in_if.sink                    in_ch,
	adsr_out_if.source                 out_ch
);
	import adsr_pkg::*;

	ctrl_cmd_t ctl_cmd;
	ctrl_sts_t ctl_sts;

	adsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	adsr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_cmd     (in_ch.cmd),
		.in_sample  (in_ch.sample_in),
		.cmd        (ctl_cmd),
		.sts        (ctl_sts),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_sample (out_ch.sample_out),
		.out_level  (out_ch.envelope_level),
		.out_phase  (out_ch.phase_out)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.load_out |-> ctl_sts.out_free)
		else $error("result loaded over a waiting transaction");

	a_rel_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.rel_load |-> $past(ctl_cmd.step))
		else $error("release load without a preceding step");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl_cmd.take, ctl_cmd.step, ctl_cmd.rel_load, ctl_cmd.load_out}))
		else $error("overlapping datapath commands");

	a_cmd_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_cmd.take && !ctl_sts.is_sample) |=> !ctl_cmd.step)
		else $error("command transaction started an envelope step");

endmodule

// ===== design/adsr_ctrl.sv =====
// Sequencer for the envelope gain: accept, step, optional release multiply,
// gain multiply, result load. Depends on adsr_pkg for command and status structs.
module adsr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  adsr_pkg::ctrl_sts_t  sts,
	output adsr_pkg::ctrl_cmd_t  cmd
);
	import adsr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_REL,
		S_GAIN,
		S_LOAD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && sts.is_sample) state_q <= S_STEP;
				end
				S_STEP: begin
					state_q <= sts.rel_mul ? S_REL : S_GAIN;
				end
				S_REL: begin
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.take     = (state_q == S_IDLE) && in_valid;
		cmd.step     = (state_q == S_STEP);
		cmd.rel_load = (state_q == S_REL);
		cmd.mul_en   = ((state_q == S_STEP) && sts.rel_mul) || (state_q == S_GAIN);
		cmd.mul_rel  = (state_q == S_STEP);
		cmd.load_out = (state_q == S_LOAD) && sts.out_free;
	end

endmodule

// ===== design/adsr_dp.sv =====
// Datapath: configuration registers, envelope and phase state, shared multiplier
// and result register. Depends on adsr_pkg for types and constants.
module adsr_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [adsr_pkg::IDX_W-1:0] cfg_idx,
	input  logic [adsr_pkg::LVL_W-1:0] cfg_data,
	input  logic [adsr_pkg::CMD_W-1:0] in_cmd,
	input  logic signed [adsr_pkg::SMP_W-1:0] in_sample,
	input  adsr_pkg::ctrl_cmd_t        cmd,
	output adsr_pkg::ctrl_sts_t        sts,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic signed [adsr_pkg::SMP_W-1:0] out_sample,
	output logic [adsr_pkg::LVL_W-1:0] out_level,
	output logic [adsr_pkg::PH_W-1:0]  out_phase
);
	import adsr_pkg::*;

	logic [LVL_W-1:0]        atk_q;
	logic [LVL_W-1:0]        dec_q;
	logic [LVL_W-1:0]        sus_q;
	logic [RF_W-1:0]         rf_q;
	phase_t                  phase_q;
	logic [LVL_W-1:0]        env_q;
	logic signed [SMP_W-1:0] smp_q;
	logic [2*SMP_W-1:0]      prod_q;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_sample_q;
	logic [LVL_W-1:0]        out_level_q;
	phase_t                  out_phase_q;

	logic [LVL_W:0]          atk_sum;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	assign atk_sum = {1'b0, env_q} + {1'b0, atk_q};

	always_comb begin
		if (cmd.mul_rel) begin
			mul_a = $signed({1'b0, env_q});
			mul_b = $signed({2'b00, rf_q});
		end else begin
			mul_a = $signed({{(MUL_W-SMP_W){smp_q[SMP_W-1]}}, smp_q});
			mul_b = $signed({1'b0, env_q});
		end
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atk_q <= RST_ATTACK;
			dec_q <= RST_DECAY;
			sus_q <= RST_SUSTAIN;
			rf_q  <= RST_RELEASE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_ATTACK:  atk_q <= cfg_data;
				REG_DECAY:   dec_q <= cfg_data;
				REG_SUSTAIN: sus_q <= cfg_data;
				REG_RELEASE: rf_q  <= cfg_data[RF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			env_q   <= '0;
		end else if (cmd.take) begin
			case (cmd_t'(in_cmd))
				CMD_NOTE_ON:  phase_q <= PH_ATTACK;
				CMD_NOTE_OFF: phase_q <= PH_RELEASE;
				CMD_RESET: begin
					phase_q <= PH_IDLE;
					env_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.step) begin
			case (phase_q)
				PH_ATTACK: begin
					if (env_q < LEVEL_ONE) begin
						env_q <= (atk_sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : atk_sum[LVL_W-1:0];
					end else begin
						phase_q <= PH_DECAY;
					end
				end
				PH_DECAY: begin
					if (env_q > sus_q) begin
						env_q <= (env_q > dec_q) ? (env_q - dec_q) : '0;
					end else begin
						phase_q <= PH_SUSTAIN;
					end
				end
				PH_RELEASE: begin
					if (env_q == '0) begin
						phase_q <= PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.rel_load) begin
			env_q <= {1'b0, prod_q[2*SMP_W-1:SMP_W]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) smp_q <= in_sample;
		if (cmd.mul_en) prod_q <= mul_p[2*SMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_sample_q <= $signed(prod_q[2*SMP_W-1:SMP_W]);
			out_level_q  <= env_q;
			out_phase_q  <= phase_q;
		end
	end

	assign sts.is_sample = (cmd_t'(in_cmd) == CMD_SAMPLE);
	assign sts.rel_mul   = (phase_q == PH_RELEASE) && (env_q != '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_level  = out_level_q;
	assign out_phase  = out_phase_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for adsr_envelope_gain_top: drives command and sample
// transactions, predicts every result and compares it field by field.
// Depends on adsr_pkg, adsr_in_if and adsr_out_if from the design.
module tb_top;
	import adsr_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYC  = 12;
	localparam int HOLD_CYC    = 300;

	typedef struct {
		cmd_t                    cmd;
		logic signed [SMP_W-1:0] smp;
	} note_item_t;

	typedef struct {
		logic signed [SMP_W-1:0] smp;
		logic [LVL_W-1:0]        lvl;
		phase_t                  ph;
	} gain_res_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [LVL_W-1:0] cfg_data;

	adsr_in_if  in_ch ();
	adsr_out_if out_ch ();

	adsr_envelope_gain_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	note_item_t stim_q[$];
	gain_res_t  gain_q[$];

	logic [LVL_W-1:0] attack_r;
	logic [LVL_W-1:0] decay_r;
	logic [LVL_W-1:0] sustain_r;
	logic [RF_W-1:0]  release_r;
	phase_t           env_phase;
	logic [LVL_W-1:0] env_lvl;

	int        err_cnt;
	int        items_queued;
	int        stall_cnt;
	int        in_gap;
	int        out_gap;
	int        sink_hold;
	bit        idle_en;
	bit        in_acc;
	bit        nv;
	bit        rdy;
	gain_res_t got;
	gain_res_t want;

	always #5 clk = ~clk;

	function automatic void envelope_step(cmd_t c, logic signed [SMP_W-1:0] s);
		logic [31:0] sum;
		logic [63:0] rel;
		longint      prod;
		gain_res_t   r;
		case (c)
			CMD_NOTE_ON: env_phase = PH_ATTACK;
			CMD_NOTE_OFF: env_phase = PH_RELEASE;
			CMD_RESET: begin
				env_phase = PH_IDLE;
				env_lvl = '0;
			end
			default: begin
				case (env_phase)
					PH_ATTACK: begin
						if (env_lvl < LEVEL_ONE) begin
							sum = {7'd0, env_lvl} + {7'd0, attack_r};
							env_lvl = (sum > {7'd0, LEVEL_ONE}) ? LEVEL_ONE : sum[LVL_W-1:0];
						end else begin
							env_phase = PH_DECAY;
						end
					end
					PH_DECAY: begin
						if (env_lvl > sustain_r)
							env_lvl = (env_lvl > decay_r) ? env_lvl - decay_r : '0;
						else
							env_phase = PH_SUSTAIN;
					end
					PH_RELEASE: begin
						if (env_lvl != '0) begin
							rel = {39'd0, env_lvl} * {40'd0, release_r};
							env_lvl = rel[48:24];
						end else begin
							env_phase = PH_IDLE;
							env_lvl = '0;
						end
					end
					default: ;
				endcase
				prod = longint'(s) * longint'(env_lvl);
				r.smp = prod[47:24];
				r.lvl = env_lvl;
				r.ph = env_phase;
				gain_q.push_back(r);
			end
		endcase
	endfunction

	task automatic flag_error(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endtask

	task automatic push_item(cmd_t c, logic signed [SMP_W-1:0] s);
		note_item_t it;
		it.cmd = c;
		it.smp = s;
		stim_q.push_back(it);
		items_queued++;
	endtask

	function automatic logic signed [SMP_W-1:0] rand_sample();
		int sel;
		sel = $urandom_range(0, 15);
		case (sel)
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return '0;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	task automatic settle();
		while (stim_q.size() != 0 || in_ch.valid || gain_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [LVL_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ATTACK: attack_r = val;
			REG_DECAY: decay_r = val;
			REG_SUSTAIN: sustain_r = val;
			default: release_r = val[RF_W-1:0];
		endcase
	endtask

	task automatic load_regs(logic [LVL_W-1:0] a, logic [LVL_W-1:0] d,
		logic [LVL_W-1:0] s, logic [LVL_W-1:0] r);
		settle();
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_SUSTAIN, s);
		write_reg(REG_RELEASE, r);
	endtask

	task automatic queue_note();
		push_item(CMD_NOTE_ON, rand_sample());
		repeat ($urandom_range(1, 40)) push_item(CMD_SAMPLE, rand_sample());
		push_item(CMD_NOTE_OFF, rand_sample());
		repeat ($urandom_range(1, 30)) push_item(CMD_SAMPLE, rand_sample());
	endtask

	task automatic random_phase(int n);
		int stop_at;
		int sel;
		stop_at = items_queued + n;
		while (items_queued < stop_at) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				push_item(cmd_t'($urandom_range(0, 3)), rand_sample());
			else if (sel == 1)
				push_item(CMD_RESET, rand_sample());
			else
				queue_note();
		end
	endtask

	task automatic random_regs_phase(int n);
		load_regs(LVL_W'($urandom_range(1 << 19, 1 << 24)),
			LVL_W'($urandom_range(1 << 19, 1 << 24)),
			LVL_W'($urandom_range(0, 1 << 24)), LVL_W'($urandom_range(0, 12000000)));
		random_phase(n);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				envelope_step(cmd_t'(in_ch.cmd), in_ch.sample_in);
				in_acc <= 1'b1;
			end else begin
				in_acc <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_acc)
				void'(stim_q.pop_front());
			nv = in_ch.valid && !in_acc;
			if (!nv) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (stim_q.size() != 0) begin
					if (idle_en && $urandom_range(0, 5) == 0)
						in_gap = $urandom_range(0, 4);
					else
						nv = 1'b1;
				end
			end
			in_ch.valid <= nv;
			if (nv) begin
				in_ch.cmd <= stim_q[0].cmd;
				in_ch.sample_in <= stim_q[0].smp;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			rdy = 1'b0;
			if (sink_hold > 0) begin
				sink_hold--;
			end else if (out_gap > 0) begin
				out_gap--;
			end else if (idle_en && $urandom_range(0, 6) == 0) begin
				out_gap = $urandom_range(0, 4);
			end else begin
				rdy = 1'b1;
			end
			out_ch.ready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.smp = out_ch.sample_out;
			got.lvl = out_ch.envelope_level;
			got.ph = phase_t'(out_ch.phase_out);
			if (gain_q.size() == 0) begin
				flag_error($sformatf("unexpected result: sample %0d level %0d phase %0d",
					got.smp, got.lvl, got.ph));
			end else begin
				want = gain_q.pop_front();
				if (got.smp !== want.smp || got.lvl !== want.lvl || got.ph !== want.ph)
					flag_error($sformatf(
						"mismatch: sample exp %0d got %0d, level exp %0d got %0d, phase exp %0d got %0d",
						want.smp, got.smp, want.lvl, got.lvl, want.ph, got.ph));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("** adsr_envelope_gain_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.sample_in = '0;
		out_ch.ready = 1'b0;
		attack_r = RST_ATTACK;
		decay_r = RST_DECAY;
		sustain_r = RST_SUSTAIN;
		release_r = RST_RELEASE;
		env_phase = PH_IDLE;
		env_lvl = '0;
		err_cnt = 0;
		items_queued = 0;
		stall_cnt = 0;
		in_gap = 0;
		out_gap = 0;
		sink_hold = 0;
		idle_en = 1'b1;
		in_acc = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_item(CMD_SAMPLE, 24'sh7FFFFF);
		push_item(CMD_SAMPLE, 24'sh800000);
		push_item(CMD_NOTE_OFF, '0);
		push_item(CMD_SAMPLE, 24'sh123456);
		push_item(CMD_SAMPLE, 24'sh7FFFFF);
		push_item(CMD_NOTE_ON, '0);
		push_item(CMD_SAMPLE, 24'sh7FFFFF);
		push_item(CMD_SAMPLE, 24'sh800000);

		load_regs(LEVEL_ONE, LEVEL_ONE, '0, '0);
		push_item(CMD_RESET, '0);
		push_item(CMD_NOTE_ON, '0);
		push_item(CMD_SAMPLE, 24'sh7FFFFF);
		push_item(CMD_SAMPLE, 24'sh800000);
		push_item(CMD_SAMPLE, 24'sh7FFFFF);
		push_item(CMD_SAMPLE, 24'sh800000);
		push_item(CMD_SAMPLE, rand_sample());
		push_item(CMD_NOTE_OFF, '0);
		push_item(CMD_SAMPLE, 24'sh7FFFFF);
		push_item(CMD_SAMPLE, 24'sh800000);
		push_item(CMD_NOTE_ON, '0);
		push_item(CMD_SAMPLE, 24'sh7FFFFF);
		push_item(CMD_RESET, '0);
		push_item(CMD_SAMPLE, 24'sh7FFFFF);

		load_regs(LVL_W'(1 << 20), LVL_W'(1 << 21), LVL_W'(1 << 23), LVL_W'(1 << 23));
		sink_hold = HOLD_CYC;
		random_phase(130);
		load_regs('0, 25'd1, LEVEL_ONE, 25'h0FFFFFF);
		random_phase(60);
		load_regs(LEVEL_ONE, 25'd1, LEVEL_ONE, 25'h0FFFFFF);
		random_phase(60);
		load_regs(25'd1, LEVEL_ONE, '0, '0);
		random_phase(60);
		repeat (3) random_regs_phase(130);
		settle();
		idle_en = 1'b0;
		random_regs_phase(130);
		settle();

		if (err_cnt == 0 && gain_q.size() == 0)
			$display("** adsr_envelope_gain_top: PASSED **");
		else
			$display("** adsr_envelope_gain_top: FAILED **");
		$finish;
	end
endmodule
